/* design/rsc_pkg.sv */
// rsc_pkg: constants and helpers shared by the radix string converter
// core and its port checker
// no dependencies
package rsc_pkg;

  localparam int VALUE_BITS_DEF = 32;
  localparam int BASE_W         = 5;
  localparam int PADDR_W        = 3;
  localparam int PDATA_W        = 32;

  localparam logic [BASE_W-1:0] BASE_RESET = 5'd10;
  localparam logic [BASE_W-1:0] MIN_RADIX  = 5'd2;
  localparam logic [BASE_W-1:0] MAX_RADIX  = 5'd16;

  // register index, taken from paddr bit 2
  localparam logic REG_SRC_BASE = 1'b0;
  localparam logic REG_TGT_BASE = 1'b1;

  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_F = 8'h46;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7a;
  localparam logic [7:0] CH_MINUS   = 8'h2d;
  localparam logic [7:0] CASE_GAP   = 8'h20;

  function automatic logic [7:0] digit_char(input logic [3:0] r);
    logic [7:0] ch;
    if (r < 4'd10) begin
      ch = CH_ZERO + {4'd0, r};
    end else begin
      ch = CH_UPPER_A + {4'd0, r} - 8'd10;
    end
    return ch;
  endfunction

endpackage

/* design/radix_string_converter_core.sv */
// radix_string_converter_core: folds an ascii numeral into a binary value and
// re-emits it in the target radix through a bit-serial restoring divider
// depends on rsc_pkg
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+----------------------------------------
//  in      | sink      | in_valid_i / in_stall_o   | char_in_i, final_char_i
//  out     | source    | out_valid_o / out_stall_i | char_out_o, end_of_number_o, bad_base_o
//  apb     | slave     | psel, penable, pready     | paddr, pwdata, prdata
//
// a non-final item is absorbed in the cycle it is taken
// a final item passes sign handling (S_PREP, S_ABS), then S_DIV and S_STORE per output digit (one
// quotient bit per cycle in S_DIV), then the sign slot S_SIGN, then S_READ and S_EMIT per digit
// in_stall_o is high from a final item until its last character is loaded
// out_stall_i holds the output register; each output step waits for the slot to free
// reset restores both radices to ten and re-arms for a new numeral
module radix_string_converter_core
  import rsc_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          char_in_i,
  input  logic                final_char_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [7:0]          char_out_o,
  output logic                end_of_number_o,
  output logic                bad_base_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready
);

  localparam int CntW = $clog2(VALUE_BITS);
  localparam int IdxW = $clog2(VALUE_BITS);
  localparam int NdW  = $clog2(VALUE_BITS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_ABS, S_BAD, S_ZERO, S_DIV, S_STORE, S_SIGN, S_READ, S_EMIT
  } state_e;

  state_e                 state_q, state_d;
  logic [BASE_W-1:0]      src_base_q, src_base_d;
  logic [BASE_W-1:0]      tgt_base_q, tgt_base_d;
  logic [VALUE_BITS-1:0]  acc_q, acc_d;
  logic                   neg_q, neg_d;
  logic                   first_q, first_d;
  logic [VALUE_BITS-1:0]  mag_q, mag_d;
  logic                   isneg_q, isneg_d;
  logic [3:0]             rem_q, rem_d;
  logic [CntW-1:0]        bcnt_q, bcnt_d;
  logic [NdW-1:0]         nd_q, nd_d;
  logic                   out_valid_q, out_valid_d;
  logic [7:0]             char_q, char_d;
  logic                   eon_q, eon_d;
  logic                   bad_q, bad_d;

  logic [3:0]             mem [VALUE_BITS];
  logic [3:0]             rd_q;
  logic                   mem_we;
  logic [IdxW-1:0]        widx, ridx;

  logic                   in_acc, cfg_we, out_free, tgt_bad, is_dec;
  logic [7:0]             ch_up;
  logic signed [8:0]      dig_s;
  logic [VALUE_BITS-1:0]  prod;
  logic [4:0]             div_t;
  logic                   div_ge;

  assign in_stall_o      = (state_q != S_IDLE);
  assign in_acc          = in_valid_i && !in_stall_o;
  assign out_free        = !out_valid_q || !out_stall_i;
  assign cfg_we          = psel && penable && pwrite;
  assign pready          = 1'b1;
  assign prdata          = (paddr[2] == REG_TGT_BASE) ? PDATA_W'(tgt_base_q)
                                                      : PDATA_W'(src_base_q);
  assign out_valid_o     = out_valid_q;
  assign char_out_o      = char_q;
  assign end_of_number_o = eon_q;
  assign bad_base_o      = bad_q;

  assign tgt_bad = (tgt_base_q < MIN_RADIX) || (tgt_base_q > MAX_RADIX);

  // character to signed digit value
  assign is_dec = (char_in_i >= CH_ZERO) && (char_in_i <= CH_NINE);
  assign ch_up  = ((char_in_i >= CH_LOWER_A) && (char_in_i <= CH_LOWER_Z))
                  ? char_in_i - CASE_GAP : char_in_i;
  assign dig_s  = is_dec ? signed'({1'b0, char_in_i} - {1'b0, CH_ZERO})
                         : signed'({1'b0, ch_up} - {1'b0, CH_UPPER_A} + 9'd10);

  // acc * source base as a five-term shift-add
  always_comb begin
    prod = '0;
    for (int i = 0; i < BASE_W; i++) begin
      if (src_base_q[i]) begin
        prod = prod + (acc_q << i);
      end
    end
  end

  // one restoring division step
  assign div_t  = {rem_q, mag_q[VALUE_BITS-1]};
  assign div_ge = (div_t >= tgt_base_q);

  assign widx = nd_q[IdxW-1:0];
  assign ridx = IdxW'(nd_q - NdW'(1));

  always_comb begin
    state_d     = state_q;
    src_base_d  = src_base_q;
    tgt_base_d  = tgt_base_q;
    acc_d       = acc_q;
    neg_d       = neg_q;
    first_d     = first_q;
    mag_d       = mag_q;
    isneg_d     = isneg_q;
    rem_d       = rem_q;
    bcnt_d      = bcnt_q;
    nd_d        = nd_q;
    out_valid_d = out_valid_q;
    char_d      = char_q;
    eon_d       = eon_q;
    bad_d       = bad_q;
    mem_we      = 1'b0;

    if (cfg_we) begin
      if (paddr[2] == REG_TGT_BASE) begin
        tgt_base_d = pwdata[BASE_W-1:0];
      end else begin
        src_base_d = pwdata[BASE_W-1:0];
      end
    end

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          first_d = 1'b0;
          if (first_q && (char_in_i == CH_MINUS)) begin
            neg_d = 1'b1;
          end else begin
            acc_d = prod + VALUE_BITS'(dig_s);
          end
          if (final_char_i) begin
            state_d = S_PREP;
          end
        end
      end
      S_PREP: begin
        mag_d   = neg_q ? (VALUE_BITS'(0) - acc_q) : acc_q;
        acc_d   = '0;
        neg_d   = 1'b0;
        first_d = 1'b1;
        state_d = tgt_bad ? S_BAD : S_ABS;
      end
      S_ABS: begin
        isneg_d = mag_q[VALUE_BITS-1];
        mag_d   = mag_q[VALUE_BITS-1] ? (VALUE_BITS'(0) - mag_q) : mag_q;
        rem_d   = '0;
        bcnt_d  = '0;
        nd_d    = '0;
        state_d = (mag_q == '0) ? S_ZERO : S_DIV;
      end
      S_BAD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          char_d      = '0;
          eon_d       = 1'b1;
          bad_d       = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_ZERO: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          char_d      = CH_ZERO;
          eon_d       = 1'b1;
          bad_d       = 1'b0;
          state_d     = S_IDLE;
        end
      end
      S_DIV: begin
        rem_d  = div_ge ? 4'(div_t - tgt_base_q) : div_t[3:0];
        mag_d  = {mag_q[VALUE_BITS-2:0], div_ge};
        bcnt_d = bcnt_q + CntW'(1);
        if (bcnt_q == CntW'(VALUE_BITS - 1)) begin
          state_d = S_STORE;
        end
      end
      S_STORE: begin
        mem_we  = 1'b1;
        nd_d    = nd_q + NdW'(1);
        rem_d   = '0;
        bcnt_d  = '0;
        state_d = (mag_q == '0) ? S_SIGN : S_DIV;
      end
      S_SIGN: begin
        if (!isneg_q) begin
          state_d = S_READ;
        end else if (out_free) begin
          out_valid_d = 1'b1;
          char_d      = CH_MINUS;
          eon_d       = 1'b0;
          bad_d       = 1'b0;
          state_d     = S_READ;
        end
      end
      S_READ: begin
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          char_d      = digit_char(rd_q);
          eon_d       = (nd_q == NdW'(1));
          bad_d       = 1'b0;
          nd_d        = nd_q - NdW'(1);
          state_d     = (nd_q == NdW'(1)) ? S_IDLE : S_READ;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      src_base_q  <= BASE_RESET;
      tgt_base_q  <= BASE_RESET;
      acc_q       <= '0;
      neg_q       <= 1'b0;
      first_q     <= 1'b1;
      mag_q       <= '0;
      isneg_q     <= 1'b0;
      rem_q       <= '0;
      bcnt_q      <= '0;
      nd_q        <= '0;
      out_valid_q <= 1'b0;
      char_q      <= '0;
      eon_q       <= 1'b0;
      bad_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      src_base_q  <= src_base_d;
      tgt_base_q  <= tgt_base_d;
      acc_q       <= acc_d;
      neg_q       <= neg_d;
      first_q     <= first_d;
      mag_q       <= mag_d;
      isneg_q     <= isneg_d;
      rem_q       <= rem_d;
      bcnt_q      <= bcnt_d;
      nd_q        <= nd_d;
      out_valid_q <= out_valid_d;
      char_q      <= char_d;
      eon_q       <= eon_d;
      bad_q       <= bad_d;
    end
  end

  // remainder store, least significant digit first
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[widx] <= rem_q;
    end
    rd_q <= mem[ridx];
  end

endmodule

/* design/rsc_checker.sv */
// rsc_checker: port-level checks on the radix string converter core,
// bound to every instance of the core
// depends on rsc_pkg
module rsc_checker
  import rsc_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] char_out_o,
  input logic       end_of_number_o,
  input logic       bad_base_o
);

  // a base error is a single, final item with no character
  a_bad_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_base_o |-> end_of_number_o && (char_out_o == 8'd0))
    else $error("bad base item not marked last or carries a character");

  // the input side stays stalled while a numeral is still being emitted
  a_stall_mid_number : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !end_of_number_o |-> in_stall_o)
    else $error("input taken while a numeral is still being emitted");

  // only digits of radix up to sixteen or a minus sign appear
  a_char_set : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !bad_base_o |->
      ((char_out_o >= CH_ZERO) && (char_out_o <= CH_NINE)) ||
      ((char_out_o >= CH_UPPER_A) && (char_out_o <= CH_UPPER_F)) ||
      (char_out_o == CH_MINUS))
    else $error("character outside the digit set");

  // a minus sign never ends a numeral
  a_minus_not_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (char_out_o == CH_MINUS) |-> !end_of_number_o)
    else $error("minus sign marked as last character");

  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(char_out_o) &&
      $stable(end_of_number_o) && $stable(bad_base_o))
    else $error("stalled output item changed");

endmodule

bind radix_string_converter_core rsc_checker u_rsc_checker (.*);
